// File: rtl/rsa_modular_exponentiation_top_defines.svh
// assertion macros for the modular exponentiation block
`ifndef RSA_MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RME_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rsa_me_pkg.sv
// shared types, constants and command codes of the modular exponentiation block
`timescale 1ns / 1ps

package rsa_me_pkg;

    localparam int VALUE_WIDTH   = 16;
    localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
    localparam int CNT_WIDTH     = $clog2(PROD_WIDTH);
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CMD_WIDTH     = 4;

    typedef logic [VALUE_WIDTH-1:0]   t_word;
    typedef logic [PROD_WIDTH-1:0]    t_prod;
    typedef logic [CNT_WIDTH-1:0]     t_cnt;
    typedef logic [CFG_IDX_WIDTH-1:0] t_cfg_idx;
    typedef logic [CMD_WIDTH-1:0]     t_cmd;

    localparam t_cfg_idx CFG_PUB_EXP  = 2'd0;
    localparam t_cfg_idx CFG_PRIV_EXP = 2'd1;
    localparam t_cfg_idx CFG_MODULUS  = 2'd2;

    localparam t_word PUB_EXP_RESET  = t_word'(5);
    localparam t_word PRIV_EXP_RESET = t_word'(173);
    localparam t_word MODULUS_RESET  = t_word'(323);

    localparam t_cmd CMD_NONE        = 4'd0;
    localparam t_cmd CMD_LOAD        = 4'd1;
    localparam t_cmd CMD_MUL_ACC     = 4'd2;
    localparam t_cmd CMD_MUL_SQ      = 4'd3;
    localparam t_cmd CMD_REDUCE      = 4'd4;
    localparam t_cmd CMD_WR_SQ       = 4'd5;
    localparam t_cmd CMD_WR_SQ_SHIFT = 4'd6;
    localparam t_cmd CMD_WR_ACC      = 4'd7;
    localparam t_cmd CMD_WR_OUT      = 4'd8;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic red_last;
    } t_status;

endpackage

// File: rtl/rsa_me_ctrl.sv
// controller state machine: sequences square-and-multiply and the handshakes
`timescale 1ns / 1ps

module rsa_me_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  rsa_me_pkg::t_status i_status,
    output rsa_me_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RED    = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_MULSQ  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [1:0] TGT_BASE = 2'd0;
    localparam logic [1:0] TGT_ACC  = 2'd1;
    localparam logic [1:0] TGT_SQ   = 2'd2;

    logic [2:0] r_state, n_state;
    logic [1:0] r_tgt, n_tgt;
    logic       r_out_valid, n_out_valid;
    rsa_me_pkg::t_cmd cmd;

    always_comb begin
        n_state     = r_state;
        n_tgt       = r_tgt;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = rsa_me_pkg::CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd     = rsa_me_pkg::CMD_LOAD;
                    n_tgt   = TGT_BASE;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                cmd = rsa_me_pkg::CMD_REDUCE;
                if (i_status.red_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                case (r_tgt)
                    TGT_BASE: begin
                        cmd     = rsa_me_pkg::CMD_WR_SQ;
                        n_state = S_DECIDE;
                    end
                    TGT_ACC: begin
                        cmd     = rsa_me_pkg::CMD_WR_ACC;
                        n_state = S_MULSQ;
                    end
                    default: begin
                        cmd     = rsa_me_pkg::CMD_WR_SQ_SHIFT;
                        n_state = S_DECIDE;
                    end
                endcase
            end
            S_DECIDE: begin
                if (i_status.exp_zero) begin
                    n_state = S_DONE;
                end else if (i_status.exp_lsb) begin
                    cmd     = rsa_me_pkg::CMD_MUL_ACC;
                    n_tgt   = TGT_ACC;
                    n_state = S_RED;
                end else begin
                    cmd     = rsa_me_pkg::CMD_MUL_SQ;
                    n_tgt   = TGT_SQ;
                    n_state = S_RED;
                end
            end
            S_MULSQ: begin
                cmd     = rsa_me_pkg::CMD_MUL_SQ;
                n_tgt   = TGT_SQ;
                n_state = S_RED;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd         = rsa_me_pkg::CMD_WR_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tgt       <= TGT_BASE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tgt       <= n_tgt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// File: rtl/rsa_me_dp.sv
// datapath: key registers, multiplier, bit-serial modular reducer, result register
`timescale 1ns / 1ps

module rsa_me_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  rsa_me_pkg::t_cfg_idx   i_cfg_index,
    input  rsa_me_pkg::t_word      i_cfg_data,
    input  rsa_me_pkg::t_word      i_value,
    input  logic                   i_opcode,
    input  logic                   i_last_in,
    input  rsa_me_pkg::t_cmd       i_cmd,
    output rsa_me_pkg::t_status    o_status,
    output rsa_me_pkg::t_word      o_result_value,
    output logic                   o_last_out
);

    localparam int W = rsa_me_pkg::VALUE_WIDTH;

    rsa_me_pkg::t_word r_pub_exp, r_priv_exp, r_mod;
    rsa_me_pkg::t_word r_acc, r_sq, r_exp, r_rem;
    rsa_me_pkg::t_prod r_prod;
    rsa_me_pkg::t_cnt  r_cnt;
    logic              r_last;
    rsa_me_pkg::t_word r_out_value;
    logic              r_out_last;

    logic [W:0]        shifted;
    logic [W:0]        trial;
    rsa_me_pkg::t_word rem_next;
    logic              mod_lt2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pub_exp  <= rsa_me_pkg::PUB_EXP_RESET;
            r_priv_exp <= rsa_me_pkg::PRIV_EXP_RESET;
            r_mod      <= rsa_me_pkg::MODULUS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rsa_me_pkg::CFG_PUB_EXP:  r_pub_exp  <= i_cfg_data;
                rsa_me_pkg::CFG_PRIV_EXP: r_priv_exp <= i_cfg_data;
                rsa_me_pkg::CFG_MODULUS:  r_mod      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // one restoring step: remainder stays below the modulus
    always_comb begin
        shifted  = {r_rem, r_prod[rsa_me_pkg::PROD_WIDTH-1]};
        trial    = shifted - {1'b0, r_mod};
        rem_next = (shifted >= {1'b0, r_mod}) ? trial[W-1:0] : shifted[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            rsa_me_pkg::CMD_LOAD: begin
                r_exp  <= i_opcode ? r_priv_exp : r_pub_exp;
                r_prod <= rsa_me_pkg::t_prod'(i_value);
                r_acc  <= rsa_me_pkg::t_word'(1);
                r_last <= i_last_in;
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            rsa_me_pkg::CMD_MUL_ACC: begin
                r_prod <= rsa_me_pkg::t_prod'(r_acc) * rsa_me_pkg::t_prod'(r_sq);
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            rsa_me_pkg::CMD_MUL_SQ: begin
                r_prod <= rsa_me_pkg::t_prod'(r_sq) * rsa_me_pkg::t_prod'(r_sq);
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            rsa_me_pkg::CMD_REDUCE: begin
                r_rem  <= rem_next;
                r_prod <= {r_prod[rsa_me_pkg::PROD_WIDTH-2:0], 1'b0};
                r_cnt  <= r_cnt + rsa_me_pkg::t_cnt'(1);
            end
            rsa_me_pkg::CMD_WR_SQ: begin
                r_sq <= r_rem;
            end
            rsa_me_pkg::CMD_WR_SQ_SHIFT: begin
                r_sq  <= r_rem;
                r_exp <= {1'b0, r_exp[W-1:1]};
            end
            rsa_me_pkg::CMD_WR_ACC: begin
                r_acc <= r_rem;
            end
            rsa_me_pkg::CMD_WR_OUT: begin
                r_out_value <= mod_lt2 ? '0 : r_acc;
                r_out_last  <= r_last;
            end
            default: begin
            end
        endcase
    end

    assign mod_lt2 = (r_mod[W-1:1] == '0);

    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_lsb  = r_exp[0];
    assign o_status.red_last =
        (r_cnt == rsa_me_pkg::t_cnt'(rsa_me_pkg::PROD_WIDTH - 1));

    assign o_result_value = r_out_value;
    assign o_last_out     = r_out_last;

endmodule

// File: rtl/rsa_modular_exponentiation_top.sv
// top level of the modular exponentiation block: controller, datapath, assertions
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_value, i_opcode, i_last_in
//  out       output     o_out_valid / i_out_stall o_result_value, o_last_out
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// one item at a time; each modular product is a multiply, 2*VALUE_WIDTH
// reduction steps in the bit-serial reducer and a write back
// reset is synchronous, active low; key registers reset to 5, 173 and 323
// a new item is taken while the previous result still waits in the output register
// a stalled result holds the engine in its final state until the output is taken
`timescale 1ns / 1ps
`include "rsa_modular_exponentiation_top_defines.svh"

module rsa_modular_exponentiation_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  rsa_me_pkg::t_cfg_idx  i_cfg_index,
    input  rsa_me_pkg::t_word     i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rsa_me_pkg::t_word     i_value,
    input  logic                  i_opcode,
    input  logic                  i_last_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rsa_me_pkg::t_word     o_result_value,
    output logic                  o_last_out
);

    rsa_me_pkg::t_cmd    cmd;
    rsa_me_pkg::t_status status;

    rsa_me_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rsa_me_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_value        (i_value),
        .i_opcode       (i_opcode),
        .i_last_in      (i_last_in),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_value (o_result_value),
        .o_last_out     (o_last_out)
    );

    // an accepted item keeps the engine busy for at least the reduction
    `RME_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "engine not busy after item accepted")
    // a new result appears only at the end of an item's work
    `RME_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result raised without work in progress")

endmodule

// File: verif/tb_rsa_modular_exponentiation_top.sv
// self-checking testbench of the modular exponentiation block with a power-mod scoreboard
`timescale 1ns / 1ps

module tb_rsa_modular_exponentiation_top;
    import rsa_me_pkg::*;

    localparam logic     OP_ENCRYPT = 1'b0;
    localparam logic     OP_DECRYPT = 1'b1;
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct {
        t_word power;
        logic  last;
    } t_power_item;

    class power_ledger;
        t_word       pub_exp;
        t_word       priv_exp;
        t_word       modulus;
        t_power_item waiting[$];
        int          failures;

        function new();
            pub_exp  = PUB_EXP_RESET;
            priv_exp = PRIV_EXP_RESET;
            modulus  = MODULUS_RESET;
            failures = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, t_word data);
            case (idx)
                CFG_PUB_EXP: begin
                    pub_exp = data;
                end
                CFG_PRIV_EXP: begin
                    priv_exp = data;
                end
                CFG_MODULUS: begin
                    modulus = data;
                end
                default: begin
                end
            endcase
        endfunction

        function t_word power_mod(t_word base, t_word expo, t_word m);
            longint unsigned acc;
            longint unsigned sq;
            longint unsigned mm;
            t_word           e;
            if (m < 2) begin
                return '0;
            end
            mm  = m;
            acc = 1;
            sq  = base % mm;
            e   = expo;
            while (e != 0) begin
                if (e[0]) begin
                    acc = (acc * sq) % mm;
                end
                sq = (sq * sq) % mm;
                e  = e >> 1;
            end
            return t_word'(acc);
        endfunction

        function void note_element(t_word v, logic op, logic last);
            t_power_item it;
            it.power = power_mod(v, (op == OP_DECRYPT) ? priv_exp : pub_exp, modulus);
            it.last  = last;
            waiting.push_back(it);
        endfunction

        function void check_element(t_word power, logic last);
            t_power_item it;
            if (waiting.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected item: power %0d last %0b", power, last);
                end
                return;
            end
            it = waiting.pop_front();
            if (it.power !== power || it.last !== last) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected power %0d last %0b, got power %0d last %0b",
                             it.power, it.last, power, last);
                end
            end
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        function void close_out();
            if (waiting.size() != 0) begin
                failures++;
                $display("%0d items never came out", waiting.size());
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n     = 1'b0;
    logic     i_cfg_we    = 1'b0;
    t_cfg_idx i_cfg_index = CFG_PUB_EXP;
    t_word    i_cfg_data  = '0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_stall;
    t_word    i_value     = '0;
    logic     i_opcode    = OP_ENCRYPT;
    logic     i_last_in   = 1'b0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_word    o_result_value;
    logic     o_last_out;

    power_ledger ledger = new();
    int          sent          = 0;
    int          in_idle_pct   = 25;
    int          out_stall_pct = 60;
    int          hold_left     = 0;

    rsa_modular_exponentiation_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_opcode       (i_opcode),
        .i_last_in      (i_last_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_last_out     (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: check accepted items, then pick the stall for the next cycle
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                ledger.check_element(o_result_value, o_last_out);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, t_word data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        ledger.set_reg(idx, data);
    endtask

    task automatic set_key(t_word pub, t_word priv, t_word modulus);
        write_reg(CFG_PUB_EXP, pub);
        write_reg(CFG_PRIV_EXP, priv);
        write_reg(CFG_MODULUS, modulus);
        write_reg(CFG_UNUSED, t_word'($urandom_range(0, 65535)));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_element(t_word v, logic op, logic last);
        if (sent < 333) begin
            in_idle_pct   = 25;
            out_stall_pct = 60;
        end else if (sent < 666) begin
            in_idle_pct   = 60;
            out_stall_pct = 25;
        end else begin
            in_idle_pct   = 0;
            out_stall_pct = 0;
        end
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_opcode   <= op;
        i_last_in  <= last;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        ledger.note_element(v, op, last);
        sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (ledger.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // mostly short exponents to keep the run time sane
    function automatic t_word pick_exp();
        int r;
        r = $urandom_range(9);
        if (r < 6) begin
            return t_word'($urandom_range(0, 63));
        end else if (r < 9) begin
            return t_word'($urandom_range(0, 1023));
        end
        return t_word'($urandom_range(0, 65535));
    endfunction

    initial begin
        t_word mod_now;
        t_word v;
        int    n_items;
        int    phase;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key
        send_element(16'd0, OP_ENCRYPT, 1'b0);
        send_element(16'hffff, OP_ENCRYPT, 1'b1);
        send_element(16'd1, OP_DECRYPT, 1'b0);
        send_element(16'd322, OP_DECRYPT, 1'b1);
        send_element(16'd323, OP_DECRYPT, 1'b0);

        // zero exponent and widest exponent, largest modulus
        wait_idle();
        set_key(16'd0, 16'hffff, 16'hffff);
        send_element(16'd12345, OP_ENCRYPT, 1'b1);
        send_element(16'd2, OP_DECRYPT, 1'b0);
        send_element(16'hfffe, OP_DECRYPT, 1'b1);

        // smallest legal modulus
        wait_idle();
        set_key(16'hffff, 16'd0, 16'd2);
        send_element(16'hffff, OP_ENCRYPT, 1'b0);
        send_element(16'd0, OP_ENCRYPT, 1'b1);
        send_element(16'd7, OP_DECRYPT, 1'b0);

        // modulus below two
        wait_idle();
        set_key(16'd3, 16'd7, 16'd1);
        send_element(16'd5, OP_ENCRYPT, 1'b0);
        send_element(16'hffff, OP_DECRYPT, 1'b1);
        wait_idle();
        set_key(16'd3, 16'd7, 16'd0);
        send_element(16'd5, OP_ENCRYPT, 1'b1);
        send_element(16'd0, OP_DECRYPT, 1'b0);

        // value above modulus
        wait_idle();
        set_key(16'd17, 16'd1, 16'd1000);
        send_element(16'd54321, OP_ENCRYPT, 1'b0);
        send_element(16'hffff, OP_DECRYPT, 1'b1);

        phase = 0;
        while (sent < 1000) begin
            wait_idle();
            case ($urandom_range(9))
                0: mod_now = 16'd2;
                1: mod_now = 16'hffff;
                2, 3, 4, 5: mod_now = t_word'($urandom_range(2, 255));
                default: mod_now = t_word'($urandom_range(2, 65535));
            endcase
            set_key(pick_exp(), pick_exp(), mod_now);
            // long receiver hold-off so the block backs up into its input
            if (phase == 2) begin
                hold_left = 1500;
            end
            n_items = $urandom_range(20, 60);
            repeat (n_items) begin
                case ($urandom_range(4))
                    0: v = t_word'($urandom_range(0, mod_now - 1));
                    1: v = t_word'(mod_now + $urandom_range(0, 2) - 1);
                    2: begin
                        case ($urandom_range(2))
                            0: v = 16'd0;
                            1: v = 16'd1;
                            default: v = 16'hffff;
                        endcase
                    end
                    default: v = t_word'($urandom_range(0, 65535));
                endcase
                send_element(v, logic'($urandom_range(1)), logic'($urandom_range(1)));
            end
            phase++;
        end

        wait_idle();
        repeat (1200) @(posedge i_clk);
        ledger.close_out();
        if (ledger.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
